// ===== rtl/core/sha256sb_pkg.sv =====
// Package: SHA-256 round constants, initial hash values, types and helper functions.
`timescale 1ns / 1ps

package sha256sb_pkg;

    localparam int ROUNDS = 64;
    localparam int WIN    = 16;

    localparam logic [31:0] PAD_WORD4  = 32'h8000_0000;
    localparam logic [31:0] PAD_ZERO   = 32'h0000_0000;
    localparam logic [31:0] LEN_WORD15 = 32'h0000_0080;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // working variables a..h
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } t_work;

    // message schedule window, entry 0 is the word used by the current round
    typedef logic [WIN-1:0][31:0] t_sched;

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha256sb_round.sv =====
// One registered SHA-256 compression round with its message schedule step.
`timescale 1ns / 1ps

module sha256sb_round #(
    parameter int ROUND_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sha256sb_pkg::t_work  i_work,
    input  sha256sb_pkg::t_sched i_sched,
    output logic                 o_valid,
    output sha256sb_pkg::t_work  o_work,
    output sha256sb_pkg::t_sched o_sched
);

    localparam logic [31:0] KC = sha256sb_pkg::K_TAB[ROUND_IDX];

    logic                 r_valid;
    sha256sb_pkg::t_work  r_work;
    sha256sb_pkg::t_sched r_sched;
    sha256sb_pkg::t_work  n_work;
    sha256sb_pkg::t_sched n_sched;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        maj = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);
        t1  = i_work.h + sha256sb_pkg::big_sig1(i_work.e) + ch + KC + i_sched[0];
        t2  = sha256sb_pkg::big_sig0(i_work.a) + maj;

        n_work.a = t1 + t2;
        n_work.b = i_work.a;
        n_work.c = i_work.b;
        n_work.d = i_work.c;
        n_work.e = i_work.d + t1;
        n_work.f = i_work.e;
        n_work.g = i_work.f;
        n_work.h = i_work.g;

        // slide window, append W[i+16]
        for (int k = 0; k < sha256sb_pkg::WIN - 1; k++) begin
            n_sched[k] = i_sched[k + 1];
        end
        n_sched[sha256sb_pkg::WIN - 1] = i_sched[0] + sha256sb_pkg::small_sig0(i_sched[1])
                                         + i_sched[9] + sha256sb_pkg::small_sig1(i_sched[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_sched <= n_sched;
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign o_sched = r_sched;

endmodule

// ===== rtl/core/sha256_single_block_128bit_word0.sv =====
// Top level: fully unrolled SHA-256 single-block pipeline returning digest word 0.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start / busy         | i_msg_word0 .. i_msg_word3 (32 b each)
//  result   | o_done (1-cycle)     | o_digest_word0 (32 b)
//
//  One transaction per cycle: 64 round stages plus one final add stage, and the
//  result is registered in the add stage. Throughput is set by the
//  unrolled round chain, one round register stage per SHA-256 round.
//  busy is always low; the pipeline never stalls and the receiver cannot stall.
//  Synchronous active-low reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module sha256_single_block_128bit_word0 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_msg_word0,
    input  logic [31:0] i_msg_word1,
    input  logic [31:0] i_msg_word2,
    input  logic [31:0] i_msg_word3,
    output logic        o_done,
    output logic [31:0] o_digest_word0
);

    localparam int NR = sha256sb_pkg::ROUNDS;

    logic                 stg_valid [NR+1];
    sha256sb_pkg::t_work  stg_work  [NR+1];
    sha256sb_pkg::t_sched stg_sched [NR+1];

    logic        r_done;
    logic [31:0] r_digest;

    assign busy = 1'b0;

    always_comb begin
        stg_valid[0] = start;

        stg_work[0].a = sha256sb_pkg::IV[0];
        stg_work[0].b = sha256sb_pkg::IV[1];
        stg_work[0].c = sha256sb_pkg::IV[2];
        stg_work[0].d = sha256sb_pkg::IV[3];
        stg_work[0].e = sha256sb_pkg::IV[4];
        stg_work[0].f = sha256sb_pkg::IV[5];
        stg_work[0].g = sha256sb_pkg::IV[6];
        stg_work[0].h = sha256sb_pkg::IV[7];

        // padded single block: message, 0x80 marker, zeros, bit length
        stg_sched[0][0] = i_msg_word0;
        stg_sched[0][1] = i_msg_word1;
        stg_sched[0][2] = i_msg_word2;
        stg_sched[0][3] = i_msg_word3;
        stg_sched[0][4] = sha256sb_pkg::PAD_WORD4;
        for (int k = 5; k < sha256sb_pkg::WIN - 1; k++) begin
            stg_sched[0][k] = sha256sb_pkg::PAD_ZERO;
        end
        stg_sched[0][sha256sb_pkg::WIN - 1] = sha256sb_pkg::LEN_WORD15;
    end

    for (genvar gi = 0; gi < NR; gi++) begin : g_round
        sha256sb_round #(
            .ROUND_IDX (gi)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[gi]),
            .i_work  (stg_work[gi]),
            .i_sched (stg_sched[gi]),
            .o_valid (stg_valid[gi+1]),
            .o_work  (stg_work[gi+1]),
            .o_sched (stg_sched[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= stg_valid[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        r_digest <= sha256sb_pkg::IV[0] + stg_work[NR].a;
    end

    assign o_done         = r_done;
    assign o_digest_word0 = r_digest;

endmodule

// ===== tb/sha256_single_block_128bit_word0_test.sv =====
// Testbench for the single-block SHA-256 first-digest-word pipeline.
`timescale 1ns / 1ps

module sha256_single_block_128bit_word0_test;

    localparam int N_DIRECTED   = 14;
    localparam int N_RANDOM     = 1500;
    localparam int PIPE_LATENCY = 70;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic        known;
        logic [31:0] digest;
    } t_msg_row;

    // known = 1 only where the digest is a well-known value (empty 128-bit entropy)
    localparam t_msg_row STIM_TABLE [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h3747_08ff},
        '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
        '{32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 1'b0, 32'h0},
        '{32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa, 1'b0, 32'h0},
        '{32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
        '{32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 1'b0, 32'h0},
        '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210, 1'b0, 32'h0},
        '{32'h7fff_ffff, 32'hffff_fffe, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_msg_word0;
    logic [31:0] i_msg_word1;
    logic [31:0] i_msg_word2;
    logic [31:0] i_msg_word3;
    logic        o_done;
    logic [31:0] o_digest_word0;

    // typed-in digest travels with the transaction it belongs to
    logic        row_known;
    logic [31:0] row_digest;

    logic [31:0] digest_q [$];
    logic [31:0] expected_digest;
    int          mismatch_count;
    bit          burst_mode;

    sha256_single_block_128bit_word0 u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_msg_word0    (i_msg_word0),
        .i_msg_word1    (i_msg_word1),
        .i_msg_word2    (i_msg_word2),
        .i_msg_word3    (i_msg_word3),
        .o_done         (o_done),
        .o_digest_word0 (o_digest_word0)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // first digest word of the padded single-block hash
    function automatic logic [31:0] digest_word0_of(input logic [31:0] m0, input logic [31:0] m1,
                                                    input logic [31:0] m2, input logic [31:0] m3);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        w[0] = m0;
        w[1] = m1;
        w[2] = m2;
        w[3] = m3;
        w[4] = sha256sb_pkg::PAD_WORD4;
        for (int i = 5; i < 15; i++) w[i] = sha256sb_pkg::PAD_ZERO;
        w[15] = sha256sb_pkg::LEN_WORD15;
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = sha256sb_pkg::IV[0]; b = sha256sb_pkg::IV[1];
        c = sha256sb_pkg::IV[2]; d = sha256sb_pkg::IV[3];
        e = sha256sb_pkg::IV[4]; f = sha256sb_pkg::IV[5];
        g = sha256sb_pkg::IV[6]; h = sha256sb_pkg::IV[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + sha256sb_pkg::K_TAB[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e;
            e = d + t1;
            d = c; c = b; b = a;
            a = t1 + t2;
        end
        return sha256sb_pkg::IV[0] + a;
    endfunction

    // mostly dense random words, some sparse or saturated ones
    function automatic logic [31:0] rand_word();
        logic [31:0] bit_mask;
        bit_mask = 32'h1 << $urandom_range(0, 31);
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return bit_mask;
            3: return ~bit_mask;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    task automatic send_msg(input logic [31:0] w0, input logic [31:0] w1, input logic [31:0] w2,
                            input logic [31:0] w3, input logic known, input logic [31:0] digest,
                            input int gap);
        start       <= 1'b1;
        i_msg_word0 <= w0;
        i_msg_word1 <= w1;
        i_msg_word2 <= w2;
        i_msg_word3 <= w3;
        row_known   <= known;
        row_digest  <= digest;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // transaction capture and result checking, on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                digest_q.push_back(row_known ? row_digest
                    : digest_word0_of(i_msg_word0, i_msg_word1, i_msg_word2, i_msg_word3));
            end
            if (o_done) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected result, got %h", $time, o_digest_word0);
                    mismatch_count++;
                end else begin
                    expected_digest = digest_q.pop_front();
                    if (o_digest_word0 !== expected_digest) begin
                        $display("%0t: digest_word0 mismatch, expected %h got %h",
                                 $time, expected_digest, o_digest_word0);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_msg_word0    = '0;
        i_msg_word1    = '0;
        i_msg_word2    = '0;
        i_msg_word3    = '0;
        row_known      = 1'b0;
        row_digest     = '0;
        mismatch_count = 0;
        burst_mode     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_msg(STIM_TABLE[i].w0, STIM_TABLE[i].w1, STIM_TABLE[i].w2, STIM_TABLE[i].w3,
                     STIM_TABLE[i].known, STIM_TABLE[i].digest, (i % 4 == 3) ? 2 : 0);
        end
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            // alternate between back-to-back stretches and gappy ones
            if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2) drain();
            send_msg(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, '0, pick_gap());
        end
        drain();
        repeat (PIPE_LATENCY) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sha256sb_pkg.sv
rtl/core/sha256sb_round.sv
rtl/core/sha256_single_block_128bit_word0.sv
tb/sha256_single_block_128bit_word0_test.sv
